// ----- sv/gga_pkg.sv -----
package gga_pkg;

    // ascii codes used by the parser and the formatter
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_O      = 8'h4F;

    localparam logic [2:0] PREFIX_LEN  = 3'd6;
    localparam logic [2:0] SKIP_FIELDS = 3'd4;

    // parser phases
    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_MATCH = 4'd1,
        PH_TIME  = 4'd2,
        PH_LAT   = 4'd3,
        PH_HEMI  = 4'd4,
        PH_LON   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_ALT   = 4'd7
    } t_phase;

    // kinds of output run produced by one input byte
    typedef enum logic [2:0] {
        BK_BYTE   = 3'd0,
        BK_END    = 3'd1,
        BK_TAG_LA = 3'd2,
        BK_SEP_LO = 3'd3,
        BK_SEP_AL = 3'd4
    } t_kind;

    // parser to formatter handoff
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
    } t_burst;

    // expected byte of the "GPGGA," prefix
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_G;
            3'd1:    c = CH_P;
            3'd2:    c = CH_G;
            3'd3:    c = CH_G;
            3'd4:    c = CH_A;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    // index of the final byte of a run
    function automatic logic [2:0] burst_last_idx(input t_kind kind);
        logic [2:0] n;
        case (kind)
            BK_TAG_LA: n = 3'd2;
            BK_SEP_LO: n = 3'd5;
            BK_SEP_AL: n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // byte at position idx of a run
    function automatic logic [7:0] burst_byte(input t_kind kind, input logic [7:0] data,
                                              input logic [2:0] idx);
        logic [7:0] c;
        logic [7:0] c1;
        logic [7:0] c2;
        c1 = (kind == BK_SEP_AL) ? CH_A : CH_L;
        c2 = (kind == BK_SEP_LO) ? CH_O : ((kind == BK_SEP_AL) ? CH_L : CH_A);
        case (kind)
            BK_BYTE: c = data;
            BK_END:  c = CH_COMMA;
            BK_TAG_LA: begin
                case (idx)
                    3'd0:    c = CH_L;
                    3'd1:    c = CH_A;
                    default: c = CH_SPACE;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    c = CH_COMMA;
                    3'd1:    c = CH_CR;
                    3'd2:    c = CH_LF;
                    3'd3:    c = c1;
                    3'd4:    c = c2;
                    default: c = CH_SPACE;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ----- sv/gga_parse.sv -----
module gga_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_consume,
    output gga_pkg::t_burst     o_burst
);

    gga_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_match_pos, n_match_pos;
    logic [2:0]      r_skipped, n_skipped;

    logic [2:0] match_idx;
    logic [2:0] match_inc;
    logic [2:0] skip_inc;
    logic       is_comma;

    assign is_comma  = (i_byte == gga_pkg::CH_COMMA);
    assign match_idx = (r_match_pos >= gga_pkg::PREFIX_LEN) ? 3'd0 : r_match_pos;
    assign match_inc = match_idx + 3'd1;
    assign skip_inc  = r_skipped + 3'd1;

    // next state and the output run for the byte in hand
    always_comb begin
        n_phase        = r_phase;
        n_match_pos    = r_match_pos;
        n_skipped      = r_skipped;
        o_burst.valid  = 1'b0;
        o_burst.kind   = gga_pkg::BK_BYTE;
        o_burst.data   = i_byte;
        case (r_phase)
            gga_pkg::PH_MATCH: begin
                if (i_byte == gga_pkg::prefix_char(match_idx)) begin
                    if (match_inc >= gga_pkg::PREFIX_LEN) begin
                        n_match_pos = 3'd0;
                        n_phase     = gga_pkg::PH_TIME;
                    end else begin
                        n_match_pos = match_inc;
                    end
                end else if (i_byte == gga_pkg::CH_DOLLAR) begin
                    n_match_pos = 3'd0;
                end else begin
                    n_match_pos = 3'd0;
                    n_phase     = gga_pkg::PH_HUNT;
                end
            end
            gga_pkg::PH_TIME: begin
                if (is_comma) begin
                    o_burst.valid = 1'b1;
                    o_burst.kind  = gga_pkg::BK_TAG_LA;
                    n_phase       = gga_pkg::PH_LAT;
                end
            end
            gga_pkg::PH_LAT: begin
                o_burst.valid = 1'b1;
                if (is_comma) begin
                    o_burst.kind = gga_pkg::BK_SEP_LO;
                    n_phase      = gga_pkg::PH_HEMI;
                end
            end
            gga_pkg::PH_HEMI: begin
                if (is_comma) begin
                    n_phase = gga_pkg::PH_LON;
                end
            end
            gga_pkg::PH_LON: begin
                o_burst.valid = 1'b1;
                if (is_comma) begin
                    o_burst.kind = gga_pkg::BK_SEP_AL;
                    n_skipped    = 3'd0;
                    n_phase      = gga_pkg::PH_SKIP;
                end
            end
            gga_pkg::PH_SKIP: begin
                if (is_comma) begin
                    if (skip_inc >= gga_pkg::SKIP_FIELDS) begin
                        n_skipped = 3'd0;
                        n_phase   = gga_pkg::PH_ALT;
                    end else begin
                        n_skipped = skip_inc;
                    end
                end
            end
            gga_pkg::PH_ALT: begin
                o_burst.valid = 1'b1;
                if (is_comma) begin
                    o_burst.kind = gga_pkg::BK_END;
                    n_phase      = gga_pkg::PH_HUNT;
                end
            end
            default: begin
                n_phase = gga_pkg::PH_HUNT;
                if (i_byte == gga_pkg::CH_DOLLAR) begin
                    n_match_pos = 3'd0;
                    n_phase     = gga_pkg::PH_MATCH;
                end
            end
        endcase
        if (!i_valid) begin
            o_burst.valid = 1'b0;
        end
    end

    // parser state advances when the byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= gga_pkg::PH_HUNT;
            r_match_pos <= 3'd0;
            r_skipped   <= 3'd0;
        end else if (i_consume) begin
            r_phase     <= n_phase;
            r_match_pos <= n_match_pos;
            r_skipped   <= n_skipped;
        end
    end

endmodule

// ----- sv/gga_burst.sv -----
module gga_burst (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gga_pkg::t_burst i_burst,
    output logic            o_free,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);

    logic            r_valid;
    gga_pkg::t_kind  r_kind;
    logic [7:0]      r_data;
    logic [2:0]      r_idx;

    logic last_byte;
    logic take;

    assign last_byte = (r_idx == gga_pkg::burst_last_idx(r_kind));
    assign take      = r_valid && i_tready;
    assign o_free    = !r_valid || (take && last_byte);

    // output bytes are decoded from the held run
    assign o_tvalid = r_valid;
    assign o_tdata  = gga_pkg::burst_byte(r_kind, r_data, r_idx);
    assign o_tlast  = (r_kind == gga_pkg::BK_END);

    // run control: load a new run or step through the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (o_free) begin
            r_valid <= i_burst.valid;
            r_idx   <= 3'd0;
        end else if (take) begin
            r_idx   <= r_idx + 3'd1;
        end
    end

    // run payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_burst.valid) begin
            r_kind <= i_burst.kind;
            r_data <= i_burst.data;
        end
    end

endmodule

// ----- sv/nmea_gga_position_extractor.sv -----
// Extracts position from NMEA GGA sentences in a serial byte stream. Input bytes
// arrive on the slave side; the block waits for '$' and "GPGGA,", skips the time
// field and emits "LA <latitude>,\r\nLO <longitude>,\r\nAL <altitude>," on the
// master side, tlast marking the final comma. One byte is accepted per clock while
// the output keeps up. The comma that ends the time field emits a 3-byte tag and a
// latitude or longitude ending comma emits a 6-byte separator; the output register
// plays these out one byte a cycle while the receiver is ready, and a following byte
// with output of its own is held off until the run has played out. An accepted byte
// passes through the input register and the run register before it is output.
module nmea_gga_position_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // msg_end
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            consume;
    logic            free;
    gga_pkg::t_burst burst;

    // a byte with no output moves on even while a run drains
    assign consume       = r_in_valid && (free || !burst.valid);
    assign s_axis_tready = !r_in_valid || consume;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    gga_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_byte    (r_in_byte),
        .i_consume (consume),
        .o_burst   (burst)
    );

    gga_burst u_burst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_burst  (burst),
        .o_free   (free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ----- sv/gga_checker.sv -----
module gga_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // stalled output holds its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // the message end is always the altitude comma
    a_last_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == gga_pkg::CH_COMMA)
        else $error("message end is not a comma");

    // after a message end the parser is hunting, so nothing follows at once
    a_gap_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output right after message end");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // an input transfer right after reset has nothing ahead of it
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind nmea_gga_position_extractor gga_checker u_gga_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [47:0] GGA_PREFIX = {gga_pkg::CH_COMMA, gga_pkg::CH_A, gga_pkg::CH_G,
                                          gga_pkg::CH_G, gga_pkg::CH_P, gga_pkg::CH_G};

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_msg_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    // parser state as predicted
    gga_pkg::t_phase model_phase;
    logic [2:0]      model_match_pos;
    logic [2:0]      model_fields_skipped;

    t_msg_byte  pending_msg_bytes[$];
    t_msg_byte  next_msg_byte;

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int bytes_received;
    int messages_received;
    int mismatch_count;
    int cycle_count;

    nmea_gga_position_extractor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast)    // msg_end
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d message bytes still pending", $time,
                     pending_msg_bytes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare every output transfer with the oldest predicted byte
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            bytes_received++;
            if (m_axis_tlast === 1'b1)
                messages_received++;
            if (pending_msg_bytes.size() == 0) begin
                $display("%0t: unexpected output, expected none actual data %02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                next_msg_byte = pending_msg_bytes.pop_front();
                if (m_axis_tdata !== next_msg_byte.data) begin
                    $display("%0t: out_byte mismatch, expected %02h actual %02h",
                             $time, next_msg_byte.data, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== next_msg_byte.last) begin
                    $display("%0t: msg_end mismatch, expected %0b actual %0b",
                             $time, next_msg_byte.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_msg_byte(input logic [7:0] data, input logic last);
        t_msg_byte item;
        item.data = data;
        item.last = last;
        pending_msg_bytes.push_back(item);
    endtask

    // comma, cr, lf and the next tag
    task automatic push_separator(input logic [7:0] c1, input logic [7:0] c2);
        push_msg_byte(gga_pkg::CH_COMMA, 1'b0);
        push_msg_byte(gga_pkg::CH_CR, 1'b0);
        push_msg_byte(gga_pkg::CH_LF, 1'b0);
        push_msg_byte(c1, 1'b0);
        push_msg_byte(c2, 1'b0);
        push_msg_byte(gga_pkg::CH_SPACE, 1'b0);
    endtask

    // predict the formatted bytes caused by one received byte
    task automatic predict_gga_byte(input logic [7:0] b);
        case (model_phase)
            gga_pkg::PH_MATCH: begin
                if (model_match_pos >= gga_pkg::PREFIX_LEN)
                    model_match_pos = '0;
                if (b == GGA_PREFIX[model_match_pos*8 +: 8]) begin
                    model_match_pos = model_match_pos + 3'd1;
                    if (model_match_pos >= gga_pkg::PREFIX_LEN) begin
                        model_match_pos = '0;
                        model_phase = gga_pkg::PH_TIME;
                    end
                end else if (b == gga_pkg::CH_DOLLAR) begin
                    model_match_pos = '0;
                end else begin
                    model_match_pos = '0;
                    model_phase = gga_pkg::PH_HUNT;
                end
            end
            gga_pkg::PH_TIME: begin
                if (b == gga_pkg::CH_COMMA) begin
                    push_msg_byte(gga_pkg::CH_L, 1'b0);
                    push_msg_byte(gga_pkg::CH_A, 1'b0);
                    push_msg_byte(gga_pkg::CH_SPACE, 1'b0);
                    model_phase = gga_pkg::PH_LAT;
                end
            end
            gga_pkg::PH_LAT: begin
                if (b == gga_pkg::CH_COMMA) begin
                    push_separator(gga_pkg::CH_L, gga_pkg::CH_O);
                    model_phase = gga_pkg::PH_HEMI;
                end else begin
                    push_msg_byte(b, 1'b0);
                end
            end
            gga_pkg::PH_HEMI: begin
                if (b == gga_pkg::CH_COMMA)
                    model_phase = gga_pkg::PH_LON;
            end
            gga_pkg::PH_LON: begin
                if (b == gga_pkg::CH_COMMA) begin
                    push_separator(gga_pkg::CH_A, gga_pkg::CH_L);
                    model_fields_skipped = '0;
                    model_phase = gga_pkg::PH_SKIP;
                end else begin
                    push_msg_byte(b, 1'b0);
                end
            end
            gga_pkg::PH_SKIP: begin
                if (b == gga_pkg::CH_COMMA) begin
                    model_fields_skipped = model_fields_skipped + 3'd1;
                    if (model_fields_skipped >= gga_pkg::SKIP_FIELDS) begin
                        model_fields_skipped = '0;
                        model_phase = gga_pkg::PH_ALT;
                    end
                end
            end
            gga_pkg::PH_ALT: begin
                if (b == gga_pkg::CH_COMMA) begin
                    push_msg_byte(gga_pkg::CH_COMMA, 1'b1);
                    model_phase = gga_pkg::PH_HUNT;
                end else begin
                    push_msg_byte(b, 1'b0);
                end
            end
            default: begin
                model_phase = gga_pkg::PH_HUNT;
                if (b == gga_pkg::CH_DOLLAR) begin
                    model_match_pos = '0;
                    model_phase = gga_pkg::PH_MATCH;
                end
            end
        endcase
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge i_clk);
        while (s_axis_tready !== 1'b1);
        bytes_sent++;
        predict_gga_byte(b);
    endtask

    // random field character, never a comma, sometimes a dollar
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(0, 15) == 0)
            return gga_pkg::CH_DOLLAR;
        c = 8'($urandom_range(0, 255));
        while (c == gga_pkg::CH_COMMA)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic send_field(input int len);
        for (int i = 0; i < len; i++)
            send_byte(field_char());
        send_byte(gga_pkg::CH_COMMA);
    endtask

    task automatic send_prefix();
        send_byte(gga_pkg::CH_DOLLAR);
        for (int i = 0; i < 6; i++)
            send_byte(GGA_PREFIX[i*8 +: 8]);
    endtask

    // wait until every predicted byte has come out, then let the pipe settle
    task automatic wait_drained();
        while (pending_msg_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mismatch back to hunting, then a dollar restarting the match
    task automatic test_prefix_matching();
        send_byte(8'h58);
        send_byte(gga_pkg::CH_DOLLAR);
        send_byte(gga_pkg::CH_G);
        send_byte(8'h58);
        send_byte(gga_pkg::CH_DOLLAR);
        send_byte(gga_pkg::CH_G);
        send_byte(gga_pkg::CH_DOLLAR);
        for (int i = 0; i < 6; i++)
            send_byte(GGA_PREFIX[i*8 +: 8]);
    endtask

    // extreme bytes, dollar copied and ignored, empty longitude and altitude
    task automatic test_sentence_extremes();
        send_byte(8'h31);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(gga_pkg::CH_DOLLAR);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(8'h4E);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(gga_pkg::CH_DOLLAR);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(gga_pkg::CH_COMMA);
        send_byte(gga_pkg::CH_COMMA);
    endtask

    // mostly well-formed sentences with random content, some noise and broken prefixes
    task automatic send_random_sentence();
        int cut;
        repeat ($urandom_range(0, 3))
            send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(0, 5);
            send_byte(gga_pkg::CH_DOLLAR);
            for (int i = 0; i < cut; i++)
                send_byte(GGA_PREFIX[i*8 +: 8]);
            send_byte(8'($urandom_range(0, 255)));
            return;
        end
        send_prefix();
        send_field($urandom_range(0, 6));
        send_field(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10));
        send_field($urandom_range(0, 1));
        send_field(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 11));
        repeat (4)
            send_field($urandom_range(0, 3));
        send_field(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6));
    endtask

    task automatic test_random_sentences(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_sentence();
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 59;
        bytes_sent = 0;
        bytes_received = 0;
        messages_received = 0;
        mismatch_count = 0;
        cycle_count = 0;
        model_phase = gga_pkg::PH_HUNT;
        model_match_pos = '0;
        model_fields_skipped = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_prefix_matching();
        test_sentence_extremes();
        test_random_sentences(90);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        send_idle_pct = 59;
        recv_idle_pct = 13;
        test_random_sentences(90);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sentences(90);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        $display("covered %0d input transfers, %0d output transfers, %0d position messages",
                 bytes_sent, bytes_received, messages_received);
        $display("under sender-heavy, receiver-heavy and no idling, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_msg_bytes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- nmea_gga_position_extractor.f -----
sv/gga_pkg.sv
sv/gga_parse.sv
sv/gga_burst.sv
sv/nmea_gga_position_extractor.sv
sv/gga_checker.sv
sim/testbench.sv
